// ===== rtl/goab_pkg.sv =====
// ----------------------------------------------------------------------------
// goab_pkg
// Shared types and constants for the goal ordering block.
// ----------------------------------------------------------------------------
package goab_pkg;

  localparam int unsigned VertexW = 16;
  localparam int unsigned ColsW   = 11;
  localparam int unsigned CostW   = 17;

  localparam logic [1:0] RegGridColumns = 2'd0;
  localparam logic [1:0] RegStartVertex = 2'd1;
  localparam logic [1:0] RegStartTime   = 2'd2;
  localparam logic [1:0] RegHorizon     = 2'd3;

  localparam logic [CostW-1:0] UnreachCost = 17'h10000;

  // Result of the cost unit for one goal.
  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic [CostW-1:0]   cost;
    logic               last;
  } goal_t;

  // Stored key: cost above vertex, so a plain compare orders them.
  typedef struct packed {
    logic [CostW-1:0]   cost;
    logic [VertexW-1:0] vertex;
  } entry_t;

endpackage

// ===== rtl/goab_cost.sv =====
// ----------------------------------------------------------------------------
// goab_cost
// Splits vertex ids into row and column by restoring division, one quotient
// bit a cycle, and forms the Manhattan cost with the reachability check.
// ----------------------------------------------------------------------------
module goab_cost (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [goab_pkg::ColsW-1:0]    grid_columns_i,
  input  logic [goab_pkg::VertexW-1:0]  start_vertex_i,
  input  logic [goab_pkg::VertexW-1:0]  start_time_i,
  input  logic [goab_pkg::VertexW-1:0]  horizon_i,
  input  logic                          start_i,
  input  logic [goab_pkg::VertexW-1:0]  goal_vertex_i,
  input  logic                          last_goal_i,
  output logic                          busy_o,
  output logic                          done_o,
  output goab_pkg::goal_t               goal_o
);

  localparam int unsigned VW = goab_pkg::VertexW;
  localparam int unsigned CW = goab_pkg::ColsW;

  typedef enum logic [1:0] {StIdle, StDivStart, StDivGoal, StCost} state_e;

  state_e              state_q;
  logic [4:0]          bit_q;
  logic [VW-1:0]       quot_q;
  logic [CW-1:0]       rem_q;
  logic [VW-1:0]       srow_q;
  logic [CW-1:0]       scol_q;
  logic [VW-1:0]       vtx_q;
  logic                last_q;
  logic                done_q;
  goab_pkg::goal_t     goal_q;

  logic [CW-1:0]  cols;
  logic [VW-1:0]  dividend;
  logic [CW:0]    trial;
  logic           fits;
  logic [CW-1:0]  rem_next;
  logic [VW-1:0]  quot_next;
  logic [VW-1:0]  drow;
  logic [CW-1:0]  dcol;
  logic [VW+1:0]  distance;
  logic [VW+2:0]  arrive;
  logic [VW-1:0]  upper;

  assign cols     = (grid_columns_i == '0) ? CW'(1) : grid_columns_i;
  assign dividend = (state_q == StDivStart) ? start_vertex_i : vtx_q;
  assign trial    = {rem_q, dividend[bit_q[3:0]]};
  assign fits     = trial >= {1'b0, cols};
  assign rem_next = fits ? CW'(trial - {1'b0, cols}) : trial[CW-1:0];
  assign quot_next = {quot_q[VW-2:0], fits};

  assign drow     = (srow_q > quot_q) ? srow_q - quot_q : quot_q - srow_q;
  assign dcol     = (scol_q > rem_q) ? scol_q - rem_q : rem_q - scol_q;
  assign distance = (VW+2)'(drow) + (VW+2)'(dcol);
  assign upper    = (horizon_i == '0) ? VW'(1) : horizon_i;
  assign arrive   = (VW+3)'(start_time_i) + (VW+3)'(distance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            vtx_q   <= goal_vertex_i;
            last_q  <= last_goal_i;
            bit_q   <= 5'(VW - 1);
            quot_q  <= '0;
            rem_q   <= '0;
            state_q <= StDivStart;
          end
        end
        StDivStart, StDivGoal: begin
          quot_q <= quot_next;
          rem_q  <= rem_next;
          if (bit_q == '0) begin
            bit_q <= 5'(VW - 1);
            if (state_q == StDivStart) begin
              srow_q  <= quot_next;
              scol_q  <= rem_next;
              quot_q  <= '0;
              rem_q   <= '0;
              state_q <= StDivGoal;
            end else begin
              state_q <= StCost;
            end
          end else begin
            bit_q <= bit_q - 5'd1;
          end
        end
        StCost: begin
          goal_q.vertex <= vtx_q;
          goal_q.last   <= last_q;
          goal_q.cost   <= (arrive > (VW+3)'(upper)) ? goab_pkg::UnreachCost
                                                      : goab_pkg::CostW'(distance);
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign goal_o = goal_q;

endmodule

// ===== rtl/goab_store.sv =====
// ----------------------------------------------------------------------------
// goab_store
// Sorted goal memory. Inserts by shifting entries up one per read-compare step
// from the top, then streams the sorted run out through a one-word output
// register.
// ----------------------------------------------------------------------------
module goab_store #(
  parameter int unsigned MaxGoals = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          goal_valid_i,
  input  goab_pkg::goal_t               goal_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [goab_pkg::VertexW-1:0]  ordered_vertex_o,
  output logic [goab_pkg::VertexW-1:0]  arrival_cost_o,
  output logic                          unreachable_o,
  output logic                          last_out_o
);

  localparam int unsigned AW = (MaxGoals > 1) ? $clog2(MaxGoals) : 1;
  localparam int unsigned NW = $clog2(MaxGoals + 1);

  typedef enum logic [2:0] {StIdle, StRead, StComp, StEmitRd, StEmitWait, StEmitOut}
    state_e;

  goab_pkg::entry_t mem_q [MaxGoals];
  goab_pkg::entry_t rdata_q;

  state_e          state_q;
  logic [NW-1:0]   count_q;
  logic [NW-1:0]   idx_q;
  goab_pkg::entry_t key_q;
  logic            last_q;
  logic            out_valid_q;
  goab_pkg::entry_t out_q;
  logic            out_last_q;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  goab_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Read the entry just below the insertion hole, or the next emitted one.
  // The emit address is held while the output register is full, so the read
  // data stays put until it can be loaded.
  always_comb begin
    mem_raddr = AW'(idx_q - NW'(1));
    if (state_q == StEmitRd || state_q == StEmitWait) begin
      mem_raddr = AW'(idx_q);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_q);
    mem_wdata = key_q;
    if (state_q == StComp) begin
      mem_we = 1'b1;
      if (rdata_q > key_q) begin
        mem_wdata = rdata_q;
      end
    end else if (state_q == StRead && idx_q == '0) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (goal_valid_i) begin
            key_q  <= {goal_i.cost, goal_i.vertex};
            last_q <= goal_i.last;
            idx_q  <= count_q;
            if (count_q == NW'(MaxGoals)) begin
              idx_q   <= '0;
              state_q <= goal_i.last ? StEmitRd : StIdle;
              if (goal_i.last && count_q == '0) begin
                state_q <= StIdle;
              end
            end else begin
              state_q <= StRead;
            end
          end
        end
        StRead: begin
          if (idx_q == '0) begin
            count_q <= count_q + NW'(1);
            state_q <= last_q ? StEmitRd : StIdle;
          end else begin
            state_q <= StComp;
          end
        end
        StComp: begin
          if (rdata_q > key_q) begin
            idx_q   <= idx_q - NW'(1);
            state_q <= StRead;
          end else begin
            count_q <= count_q + NW'(1);
            idx_q   <= '0;
            state_q <= last_q ? StEmitRd : StIdle;
          end
        end
        StEmitRd: state_q <= StEmitWait;
        StEmitWait: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= rdata_q;
            out_last_q  <= (idx_q + NW'(1) == count_q);
            out_valid_q <= 1'b1;
            state_q     <= StEmitOut;
          end
        end
        StEmitOut: begin
          if (idx_q + NW'(1) == count_q) begin
            count_q <= '0;
            idx_q   <= '0;
            state_q <= StIdle;
          end else begin
            idx_q   <= idx_q + NW'(1);
            state_q <= StEmitRd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // On a first insert the read of the empty slot is skipped; the hole at
  // index zero is written directly in the read state.
  assign busy_o          = (state_q != StIdle);
  assign out_valid_o     = out_valid_q;
  assign ordered_vertex_o = out_q.vertex;
  assign unreachable_o   = out_q.cost[goab_pkg::CostW-1];
  assign arrival_cost_o  = out_q.cost[goab_pkg::CostW-1] ? '0
                                                         : out_q.cost[goab_pkg::VertexW-1:0];
  assign last_out_o      = out_last_q;

endmodule

// ===== rtl/goal_order_by_arrival_cost.sv =====
// ----------------------------------------------------------------------------
// goal_order_by_arrival_cost
// Orders goal vertex ids by Manhattan arrival cost, unreachable goals last.
// ----------------------------------------------------------------------------
// For each goal word the row and column split runs a restoring divider one
// quotient bit per cycle for the start and the goal, and insertion walks
// the sorted memory one entry per read-compare-write step. A word with
// last_goal set then streams the whole sorted run, each result read while
// the previous one waits in the output register, and the store empties.
// Goals beyond MaxGoals are dropped. No input is taken until the previous
// word is fully processed and emitted.
module goal_order_by_arrival_cost #(
  parameter int unsigned MaxGoals = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [goab_pkg::VertexW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [goab_pkg::VertexW-1:0]  goal_vertex_i,
  input  logic                          last_goal_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [goab_pkg::VertexW-1:0]  ordered_vertex_o,
  output logic [goab_pkg::VertexW-1:0]  arrival_cost_o,
  output logic                          unreachable_o,
  output logic                          last_out_o
);

  logic [goab_pkg::ColsW-1:0]   grid_columns_q;
  logic [goab_pkg::VertexW-1:0] start_vertex_q;
  logic [goab_pkg::VertexW-1:0] start_time_q;
  logic [goab_pkg::VertexW-1:0] horizon_q;

  logic            cost_busy, cost_done, store_busy, accept;
  goab_pkg::goal_t goal;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= goab_pkg::ColsW'(1);
      start_vertex_q <= '0;
      start_time_q   <= '0;
      horizon_q      <= goab_pkg::VertexW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        goab_pkg::RegGridColumns: grid_columns_q <= cfg_data_i[goab_pkg::ColsW-1:0];
        goab_pkg::RegStartVertex: start_vertex_q <= cfg_data_i;
        goab_pkg::RegStartTime:   start_time_q   <= cfg_data_i;
        goab_pkg::RegHorizon:     horizon_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !cost_busy && !cost_done && !store_busy && !out_valid_o;
  assign accept     = in_valid_i && in_ready_o;

  goab_cost u_cost (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grid_columns_i (grid_columns_q),
    .start_vertex_i (start_vertex_q),
    .start_time_i   (start_time_q),
    .horizon_i      (horizon_q),
    .start_i        (accept),
    .goal_vertex_i  (goal_vertex_i),
    .last_goal_i    (last_goal_i),
    .busy_o         (cost_busy),
    .done_o         (cost_done),
    .goal_o         (goal)
  );

  goab_store #(.MaxGoals(MaxGoals)) u_store (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .goal_valid_i     (cost_done),
    .goal_i           (goal),
    .busy_o           (store_busy),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ordered_vertex_o (ordered_vertex_o),
    .arrival_cost_o   (arrival_cost_o),
    .unreachable_o    (unreachable_o),
    .last_out_o       (last_out_o)
  );

endmodule
